// ===== rtl/eed_pkg.sv =====
package eed_pkg;

  localparam int unsigned MaxRes  = 4;
  localparam int unsigned IdxW    = $clog2(MaxRes);
  localparam int unsigned CntW    = $clog2(MaxRes + 1);
  localparam int unsigned CfgIdxW = 2;

  localparam logic [1:0] MODE_CHAR = 2'd0;
  localparam logic [1:0] MODE_SEP  = 2'd1;
  localparam logic [1:0] MODE_EOL  = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_INTERPRET = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_NEWLINE   = CfgIdxW'(1);

  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BSLASH,
    PH_HEX0,
    PH_HEX1,
    PH_OCT
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] accum;
    logic [1:0] digits;
    logic       stopped;
  } esc_state_t;

  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    logic [CntW-1:0]        count;
  } res_t;

  typedef struct packed {
    logic interpret;
    logic newline;
  } cfg_t;

  function automatic res_t push(res_t r, logic [7:0] v);
    res_t o;
    o = r;
    if (r.count < CntW'(MaxRes)) begin
      o.bytes[r.count[IdxW-1:0]] = v;
      o.count = r.count + CntW'(1);
    end
    return o;
  endfunction

  function automatic esc_state_t clear_esc(esc_state_t s);
    esc_state_t o;
    o = s;
    o.phase  = PH_IDLE;
    o.accum  = 8'h00;
    o.digits = 2'd0;
    return o;
  endfunction

  // emits whatever a pending escape holds at a boundary
  function automatic res_t flush(esc_state_t s, res_t r);
    res_t o;
    o = r;
    unique case (s.phase)
      PH_BSLASH: o = push(o, CH_BSLASH);
      PH_HEX0: begin
        o = push(o, CH_BSLASH);
        o = push(o, CH_X);
      end
      PH_HEX1, PH_OCT: o = push(o, s.accum);
      default: o = r;
    endcase
    return o;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] h;
    h = 5'd0;
    if (c >= "0" && c <= "9") begin
      h = {1'b1, c[3:0]};
    end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
      h = {1'b1, c[3:0] + 4'd9};
    end
    return h;
  endfunction

endpackage

// ===== rtl/eed_if.sv =====
interface eed_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] char_in;

  modport source(output valid, output mode, output char_in, input ready);
  modport sink(input valid, input mode, input char_in, output ready);
endinterface

interface eed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last_of_run;

  modport source(output valid, output char_out, output last_of_run, input ready);
  modport sink(input valid, input char_out, input last_of_run, output ready);
endinterface

interface eed_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [eed_pkg::CfgIdxW-1:0] index;
  logic                        data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ===== rtl/eed_decode.sv =====
module eed_decode (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic [1:0]      mode_i,
  input  logic [7:0]      char_i,
  input  eed_pkg::cfg_t   cfg_i,
  output eed_pkg::res_t   res_o
);

  eed_pkg::esc_state_t st_q, st_d;
  eed_pkg::res_t       r;
  logic [4:0]          hx;
  logic [7:0]          oct;
  logic [1:0]          nd;
  logic                is_oct;
  logic                pass_c;

  always_comb begin
    st_d   = st_q;
    r      = '0;
    pass_c = 1'b0;
    hx     = eed_pkg::hex_digit(char_i);
    oct    = {st_q.accum[4:0], char_i[2:0]};
    is_oct = (char_i >= "0") && (char_i <= "7");
    nd     = st_q.digits - 2'd1;

    if (mode_i == eed_pkg::MODE_CHAR) begin
      if (!st_q.stopped) begin
        if (!cfg_i.interpret) begin
          r    = eed_pkg::flush(st_q, r);
          st_d = eed_pkg::clear_esc(st_q);
          r    = eed_pkg::push(r, char_i);
        end else begin
          unique case (st_q.phase)
            eed_pkg::PH_BSLASH: begin
              st_d = eed_pkg::clear_esc(st_q);
              unique case (char_i)
                "a":       r = eed_pkg::push(r, 8'd7);
                "b":       r = eed_pkg::push(r, 8'd8);
                "f":       r = eed_pkg::push(r, 8'd12);
                "n":       r = eed_pkg::push(r, 8'd10);
                "r":       r = eed_pkg::push(r, 8'd13);
                "t":       r = eed_pkg::push(r, 8'd9);
                "v":       r = eed_pkg::push(r, 8'd11);
                "\\":      r = eed_pkg::push(r, eed_pkg::CH_BSLASH);
                "c":       st_d.stopped = 1'b1;
                "x":       st_d.phase = eed_pkg::PH_HEX0;
                "0": begin
                  st_d.phase  = eed_pkg::PH_OCT;
                  st_d.digits = 2'd3;
                end
                default: begin
                  if (char_i >= "1" && char_i <= "7") begin
                    st_d.phase  = eed_pkg::PH_OCT;
                    st_d.accum  = {5'd0, char_i[2:0]};
                    st_d.digits = 2'd2;
                  end else begin
                    r = eed_pkg::push(r, eed_pkg::CH_BSLASH);
                    r = eed_pkg::push(r, char_i);
                  end
                end
              endcase
            end
            eed_pkg::PH_HEX0: begin
              if (hx[4]) begin
                st_d.accum = {4'd0, hx[3:0]};
                st_d.phase = eed_pkg::PH_HEX1;
              end else begin
                r      = eed_pkg::push(r, eed_pkg::CH_BSLASH);
                r      = eed_pkg::push(r, eed_pkg::CH_X);
                st_d   = eed_pkg::clear_esc(st_q);
                pass_c = 1'b1;
              end
            end
            eed_pkg::PH_HEX1: begin
              st_d = eed_pkg::clear_esc(st_q);
              if (hx[4]) begin
                r = eed_pkg::push(r, {st_q.accum[3:0], hx[3:0]});
              end else begin
                r      = eed_pkg::push(r, st_q.accum);
                pass_c = 1'b1;
              end
            end
            eed_pkg::PH_OCT: begin
              if (is_oct && st_q.digits != 2'd0) begin
                if (nd == 2'd0) begin
                  r    = eed_pkg::push(r, oct);
                  st_d = eed_pkg::clear_esc(st_q);
                end else begin
                  st_d.accum  = oct;
                  st_d.digits = nd;
                end
              end else begin
                r      = eed_pkg::push(r, st_q.accum);
                st_d   = eed_pkg::clear_esc(st_q);
                pass_c = 1'b1;
              end
            end
            default: begin
              st_d   = eed_pkg::clear_esc(st_q);
              pass_c = 1'b1;
            end
          endcase

          // character handled as ordinary text, may open a new escape
          if (pass_c) begin
            if (char_i == eed_pkg::CH_BSLASH) begin
              st_d.phase = eed_pkg::PH_BSLASH;
            end else begin
              r = eed_pkg::push(r, char_i);
            end
          end
        end
      end
    end else if (mode_i == eed_pkg::MODE_SEP) begin
      if (!st_q.stopped) begin
        r    = eed_pkg::flush(st_q, r);
        st_d = eed_pkg::clear_esc(st_q);
        r    = eed_pkg::push(r, eed_pkg::CH_SPACE);
      end
    end else if (mode_i == eed_pkg::MODE_EOL) begin
      st_d = eed_pkg::clear_esc(st_q);
      if (st_q.stopped) begin
        st_d.stopped = 1'b0;
      end else begin
        r = eed_pkg::flush(st_q, r);
        if (cfg_i.newline) begin
          r = eed_pkg::push(r, eed_pkg::CH_CR);
          r = eed_pkg::push(r, eed_pkg::CH_LF);
        end
      end
    end
  end

  assign res_o = r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase   <= eed_pkg::PH_IDLE;
      st_q.accum   <= 8'h00;
      st_q.digits  <= 2'd0;
      st_q.stopped <= 1'b0;
    end else if (adv_i) begin
      st_q <= st_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == eed_pkg::PH_IDLE |-> (st_q.accum == 8'h00 && st_q.digits == 2'd0))
    else $error("idle escape state holds a stale value");

  a_oct_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.digits != 2'd0) == (st_q.phase == eed_pkg::PH_OCT))
    else $error("octal digit budget out of step with phase");

  a_stopped_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && st_q.stopped && mode_i != eed_pkg::MODE_EOL) |-> r.count == '0)
    else $error("output produced while stopped");

  a_unused_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && mode_i != eed_pkg::MODE_CHAR && mode_i != eed_pkg::MODE_SEP &&
     mode_i != eed_pkg::MODE_EOL) |=> $stable(st_q))
    else $error("unused mode changed the escape state");
`endif

endmodule

// ===== rtl/eed_outbuf.sv =====
module eed_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  eed_pkg::res_t     res_i,
  output logic              can_load_o,
  eed_out_if.source         out_o
);

  logic [eed_pkg::MaxRes-1:0][7:0] bytes_q;
  logic [eed_pkg::CntW-1:0]        rem_q;
  logic                            take;

  assign out_o.valid       = (rem_q != '0);
  assign out_o.char_out    = bytes_q[0];
  assign out_o.last_of_run = (rem_q == eed_pkg::CntW'(1));

  assign take       = out_o.valid && out_o.ready;
  assign can_load_o = (rem_q == '0) || (take && out_o.last_of_run);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (load_i) begin
      rem_q <= res_i.count;
    end else if (take) begin
      rem_q <= rem_q - eed_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= res_i.bytes;
    end else if (take) begin
      bytes_q <= {8'h00, bytes_q[eed_pkg::MaxRes-1:1]};
    end
  end

`ifndef NO_ASSERTIONS
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= eed_pkg::CntW'(eed_pkg::MaxRes))
    else $error("result count exceeds buffer depth");
`endif

endmodule

// ===== rtl/echo_escape_decoder.sv =====
// echo_escape_decoder: streaming echo line decoder with backslash escapes
//
// in_i   : sink channel, one transaction per item (mode: character,
//          separator or end of line, plus the character byte)
// out_o  : source channel, one transaction per output byte; last_of_run
//          marks the final byte caused by an input item
// cfg_i  : register writes, always ready; index 0 switches escape
//          decoding, index 1 enables CR LF at end of line
//
// path: an item sits in the input register, then its bytes are decoded
// in one pass into the result buffer once that buffer can take them;
// the first byte, if any, is then valid on out_o from the result buffer
// throughput: one item per cycle while each item makes at most one byte
// and out_o is not stalled; an item making more bytes holds the result
// buffer until its last byte is taken, which is what sets the rate
// a stalled receiver holds the current byte and backs up into in_i
// reset clears the escape state, empties both stages and sets the
// registers to decoding off and newline on
module echo_escape_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  eed_in_if.sink    in_i,
  eed_out_if.source out_o,
  eed_cfg_if.sink   cfg_i
);

  logic                in_vld_q;
  logic [1:0]          mode_q;
  logic [7:0]          char_q;
  logic                adv;
  logic                can_load;
  eed_pkg::cfg_t       cfg_q;
  eed_pkg::res_t       res;

  assign adv        = in_vld_q && can_load;
  assign in_i.ready = !in_vld_q || adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      mode_q <= in_i.mode;
      char_q <= in_i.char_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interpret <= 1'b0;
      cfg_q.newline   <= 1'b1;
    end else if (cfg_i.valid && cfg_i.ready) begin
      if (cfg_i.index == eed_pkg::REG_INTERPRET) begin
        cfg_q.interpret <= cfg_i.data;
      end else if (cfg_i.index == eed_pkg::REG_NEWLINE) begin
        cfg_q.newline <= cfg_i.data;
      end
    end
  end

  eed_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .mode_i (mode_q),
    .char_i (char_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  eed_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (adv),
    .res_i      (res),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule

// ===== dv/echo_escape_decoder_test.sv =====
module echo_escape_decoder_test;
  import eed_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e                 kind;
    logic [1:0]                sel;
    logic [7:0]                value;
    int                        fixed_n;
    logic [0:MaxRes-1][7:0]    fixed;
  } row_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_byte_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] ch;
  } item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #4 clk_i = ~clk_i;

  eed_in_if  in_if ();
  eed_out_if out_if ();
  eed_cfg_if cfg_if ();

  echo_escape_decoder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // directed table: fixed_n of -1 leaves the check to the decoder model
  row_t plan[$] = '{
    '{ROW_ITEM,  MODE_CHAR,   8'h00,     1, {8'h00, 24'h0}},
    '{ROW_ITEM,  MODE_CHAR,   8'hff,     1, {8'hff, 24'h0}},
    '{ROW_ITEM,  MODE_EOL,    8'h00,     2, {CH_CR, CH_LF, 16'h0}},
    '{ROW_ITEM,  MODE_UNUSED, 8'ha5,     0, 32'h0},
    '{ROW_WRITE, REG_INTERPRET, 8'h01,  -1, 32'h0},
    '{ROW_ITEM,  MODE_CHAR,   CH_BSLASH, 0, 32'h0},
    '{ROW_ITEM,  MODE_CHAR,   "n",       1, {CH_LF, 24'h0}},
    '{ROW_ITEM,  MODE_CHAR,   CH_BSLASH, 0, 32'h0},
    '{ROW_ITEM,  MODE_CHAR,   "q",       2, {CH_BSLASH, "q", 16'h0}},
    '{ROW_ITEM,  MODE_CHAR,   CH_BSLASH, -1, 32'h0},
    '{ROW_ITEM,  MODE_CHAR,   CH_X,      -1, 32'h0},
    '{ROW_ITEM,  MODE_CHAR,   "g",       -1, 32'h0},
    '{ROW_ITEM,  MODE_CHAR,   CH_BSLASH, -1, 32'h0},
    '{ROW_ITEM,  MODE_CHAR,   "0",       -1, 32'h0},
    '{ROW_ITEM,  MODE_CHAR,   "7",       -1, 32'h0},
    '{ROW_ITEM,  MODE_CHAR,   "7",       -1, 32'h0},
    '{ROW_ITEM,  MODE_CHAR,   "7",       1, {8'hff, 24'h0}},
    '{ROW_ITEM,  MODE_CHAR,   CH_BSLASH, -1, 32'h0},
    '{ROW_ITEM,  MODE_CHAR,   CH_X,      -1, 32'h0},
    '{ROW_ITEM,  MODE_EOL,    8'h00,     4, {CH_BSLASH, CH_X, CH_CR, CH_LF}},
    '{ROW_ITEM,  MODE_CHAR,   CH_BSLASH, 0, 32'h0},
    '{ROW_ITEM,  MODE_CHAR,   "c",       0, 32'h0},
    '{ROW_ITEM,  MODE_SEP,    8'h00,     0, 32'h0},
    '{ROW_ITEM,  MODE_EOL,    8'h00,     0, 32'h0},
    '{ROW_ITEM,  MODE_CHAR,   CH_BSLASH, -1, 32'h0},
    '{ROW_ITEM,  MODE_CHAR,   CH_X,      -1, 32'h0},
    '{ROW_ITEM,  MODE_CHAR,   "F",       -1, 32'h0},
    '{ROW_WRITE, REG_INTERPRET, 8'h00,  -1, 32'h0},
    '{ROW_ITEM,  MODE_CHAR,   "z",       -1, 32'h0},
    '{ROW_ITEM,  MODE_SEP,    8'h00,     1, {CH_SPACE, 24'h0}},
    '{ROW_WRITE, REG_NEWLINE, 8'h00,    -1, 32'h0},
    '{ROW_ITEM,  MODE_EOL,    8'h00,     0, 32'h0}
  };

  // bit 1 escape decoding, bit 0 newline
  logic [1:0] phase_cfg [6] = '{2'b11, 2'b10, 2'b01, 2'b11, 2'b00, 2'b11};

  // decoder model state
  phase_e     esc_phase   = PH_IDLE;
  logic [7:0] esc_accum   = 8'h00;
  logic [1:0] esc_digits  = 2'd0;
  logic       out_stopped = 1'b0;
  logic       cfg_interp  = 1'b0;
  logic       cfg_newline = 1'b1;

  logic [7:0] run_bytes[$];
  out_byte_t  pending_bytes[$];
  item_t      seq_items[$];

  int                     row_fixed_n = -1;
  logic [0:MaxRes-1][7:0] row_fixed   = '0;

  int unsigned error_count    = 0;
  int unsigned items_taken    = 0;
  int unsigned bytes_checked  = 0;
  int unsigned full_runs      = 0;
  int unsigned settings_seen  = 0;

  int unsigned stall_style = 0;
  int unsigned style_left  = 0;
  int unsigned stall_left  = 0;

  function automatic void put_byte(logic [7:0] b);
    if (run_bytes.size() < MaxRes) run_bytes.push_back(b);
  endfunction

  function automatic void drop_escape();
    esc_phase  = PH_IDLE;
    esc_accum  = 8'h00;
    esc_digits = 2'd0;
  endfunction

  // a pending escape at a boundary comes out as far as it got
  function automatic void release_escape();
    case (esc_phase)
      PH_BSLASH: put_byte(CH_BSLASH);
      PH_HEX0: begin
        put_byte(CH_BSLASH);
        put_byte(CH_X);
      end
      PH_HEX1, PH_OCT: put_byte(esc_accum);
      default: ;
    endcase
    drop_escape();
  endfunction

  function automatic void plain_char(logic [7:0] c);
    if (c == CH_BSLASH) esc_phase = PH_BSLASH;
    else put_byte(c);
  endfunction

  function automatic int hex_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void after_bslash(logic [7:0] c);
    drop_escape();
    case (c)
      "a": put_byte(8'h07);
      "b": put_byte(8'h08);
      "f": put_byte(8'h0c);
      "n": put_byte(8'h0a);
      "r": put_byte(8'h0d);
      "t": put_byte(8'h09);
      "v": put_byte(8'h0b);
      CH_BSLASH: put_byte(CH_BSLASH);
      "c": out_stopped = 1'b1;
      CH_X: esc_phase = PH_HEX0;
      "0": begin
        esc_phase  = PH_OCT;
        esc_digits = 2'd3;
      end
      default: begin
        if (c >= "1" && c <= "7") begin
          esc_phase  = PH_OCT;
          esc_accum  = {5'b0, c[2:0]};
          esc_digits = 2'd2;
        end else begin
          put_byte(CH_BSLASH);
          put_byte(c);
        end
      end
    endcase
  endfunction

  function automatic void escaped_char(logic [7:0] c);
    int h;
    h = hex_of(c);
    case (esc_phase)
      PH_BSLASH: after_bslash(c);
      PH_HEX0: begin
        if (h >= 0) begin
          esc_accum = 8'(h);
          esc_phase = PH_HEX1;
        end else begin
          put_byte(CH_BSLASH);
          put_byte(CH_X);
          drop_escape();
          plain_char(c);
        end
      end
      PH_HEX1: begin
        if (h >= 0) begin
          put_byte({esc_accum[3:0], h[3:0]});
          drop_escape();
        end else begin
          put_byte(esc_accum);
          drop_escape();
          plain_char(c);
        end
      end
      PH_OCT: begin
        if (c >= "0" && c <= "7" && esc_digits != 2'd0) begin
          esc_accum  = {esc_accum[4:0], c[2:0]};
          esc_digits = esc_digits - 2'd1;
          if (esc_digits == 2'd0) begin
            put_byte(esc_accum);
            drop_escape();
          end
        end else begin
          put_byte(esc_accum);
          drop_escape();
          plain_char(c);
        end
      end
      default: begin
        drop_escape();
        plain_char(c);
      end
    endcase
  endfunction

  function automatic void decode_item(logic [1:0] mode, logic [7:0] c);
    run_bytes.delete();
    case (mode)
      MODE_CHAR: begin
        if (!out_stopped) begin
          if (cfg_interp) begin
            escaped_char(c);
          end else begin
            release_escape();
            put_byte(c);
          end
        end
      end
      MODE_SEP: begin
        if (!out_stopped) begin
          release_escape();
          put_byte(CH_SPACE);
        end
      end
      MODE_EOL: begin
        if (out_stopped) begin
          out_stopped = 1'b0;
          drop_escape();
        end else begin
          release_escape();
          if (cfg_newline) begin
            put_byte(CH_CR);
            put_byte(CH_LF);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(string what, out_byte_t want, out_byte_t got);
    error_count++;
    if (error_count <= 10)
      $display("mismatch (%s): expected char %h last %b, got char %h last %b",
               what, want.ch, want.last, got.ch, got.last);
  endfunction

  always @(posedge clk_i) begin : scoreboard
    out_byte_t got;
    out_byte_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.char_out, out_if.last_of_run};
        bytes_checked++;
        if (pending_bytes.size() == 0) begin
          note_mismatch("nothing expected", '0, got);
        end else begin
          want = pending_bytes.pop_front();
          if (got.ch !== want.ch || got.last !== want.last)
            note_mismatch("output transaction", want, got);
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_INTERPRET: cfg_interp = cfg_if.data;
          REG_NEWLINE:   cfg_newline = cfg_if.data;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        if (in_if.mode != MODE_UNUSED) items_taken++;
        decode_item(in_if.mode, in_if.char_in);
        if (row_fixed_n >= 0) begin
          run_bytes.delete();
          for (int k = 0; k < row_fixed_n; k++) run_bytes.push_back(row_fixed[k]);
        end
        if (run_bytes.size() == MaxRes) full_runs++;
        foreach (run_bytes[k])
          pending_bytes.push_back('{run_bytes[k], k == run_bytes.size() - 1});
      end
    end
  end

  // receiver stalls, with a stall style that is redrawn at random
  always @(negedge clk_i) begin
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 3);
      style_left  = $urandom_range(20, 120);
    end else begin
      style_left--;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (stall_style)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2: out_if.ready <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 8);
            out_if.ready <= 1'b0;
          end else begin
            out_if.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  task automatic send_item(logic [1:0] mode, logic [7:0] c, int fixed_n,
                           logic [0:MaxRes-1][7:0] fixed);
    row_fixed_n = fixed_n;
    row_fixed   = fixed;
    in_if.valid   <= 1'b1;
    in_if.mode    <= mode;
    in_if.char_in <= c;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic pause_sender(int unsigned n);
    if (n != 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic void queue_item(logic [1:0] mode, logic [7:0] c);
    seq_items.push_back('{mode, c});
  endfunction

  function automatic void queue_char(logic [7:0] c);
    queue_item(MODE_CHAR, c);
  endfunction

  // mostly well-formed escapes with random content, some noise
  task automatic build_sequence();
    int unsigned pick;
    int unsigned n;
    string hex_set;
    string esc_set;
    hex_set = "0123456789abcdefABCDEF";
    esc_set = "abfnrtv\\";
    seq_items.delete();
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      n = $urandom_range(1, 4);
      repeat (n) queue_char(8'($urandom_range(0, 255)));
    end else if (pick < 30) begin
      queue_char(CH_BSLASH);
      queue_char(esc_set[$urandom_range(0, 7)]);
    end else if (pick < 45) begin
      queue_char(CH_BSLASH);
      queue_char(CH_X);
      n = $urandom_range(0, 2);
      repeat (n) queue_char(hex_set[$urandom_range(0, 21)]);
      if ($urandom_range(0, 1) != 0) queue_char(8'($urandom_range(0, 255)));
    end else if (pick < 60) begin
      queue_char(CH_BSLASH);
      n = $urandom_range(1, 4);
      repeat (n) queue_char({5'b00110, 3'($urandom_range(0, 7))});
    end else if (pick < 67) begin
      queue_char(CH_BSLASH);
      queue_char(8'($urandom_range(0, 255)));
    end else if (pick < 75) begin
      if ($urandom_range(0, 2) == 0) queue_char(CH_BSLASH);
      queue_item(MODE_SEP, 8'($urandom_range(0, 255)));
    end else if (pick < 84) begin
      if ($urandom_range(0, 2) == 0) queue_char(CH_BSLASH);
      queue_item(MODE_EOL, 8'($urandom_range(0, 255)));
    end else if (pick < 86) begin
      queue_char(CH_BSLASH);
      queue_char("c");
    end else if (pick < 89) begin
      queue_item(MODE_UNUSED, 8'($urandom_range(0, 255)));
    end else begin
      queue_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random_phase(logic [1:0] setting, int unsigned gap_max);
    int unsigned taken;
    int unsigned burst_left;
    wait_drained();
    write_reg(REG_INTERPRET, setting[1]);
    write_reg(REG_NEWLINE, setting[0]);
    settings_seen++;
    taken = 0;
    burst_left = $urandom_range(1, 24);
    while (taken < 70) begin
      build_sequence();
      foreach (seq_items[k]) begin
        if (burst_left == 0) begin
          pause_sender($urandom_range(0, gap_max));
          burst_left = $urandom_range(1, 24);
        end
        send_item(seq_items[k].mode, seq_items[k].ch, -1, '0);
        burst_left--;
        if (seq_items[k].mode != MODE_UNUSED) taken++;
      end
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
  endtask

  initial begin
    in_if.valid   = 1'b0;
    in_if.mode    = MODE_CHAR;
    in_if.char_in = 8'h00;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = REG_INTERPRET;
    cfg_if.data   = 1'b0;
    out_if.ready  = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(plan[r].sel, plan[r].value[0]);
      end else begin
        send_item(plan[r].sel, plan[r].value, plan[r].fixed_n, plan[r].fixed);
      end
    end

    foreach (phase_cfg[p])
      run_random_phase(phase_cfg[p], (p == 0) ? 0 : $urandom_range(1, 6));

    wait_drained();
    error_count += pending_bytes.size();
    $display("%0d input items taken, %0d output bytes checked, %0d items with four bytes",
             items_taken, bytes_checked, full_runs);
    $display("%0d random register settings after the directed escape cases, %0d mismatches",
             settings_seen, error_count);
    if (error_count == 0) begin
      $display("echo_escape_decoder regression: pass");
    end else begin
      $display("echo_escape_decoder regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d output bytes still expected", pending_bytes.size());
    $display("echo_escape_decoder regression: fail");
    $finish;
  end

endmodule

// ===== echo_escape_decoder.f =====
rtl/eed_pkg.sv
rtl/eed_if.sv
rtl/eed_decode.sv
rtl/eed_outbuf.sv
rtl/echo_escape_decoder.sv
dv/echo_escape_decoder_test.sv
